/* hdl/modular_inverse_euclid_unit_assert.svh */
// ----------------------------------------------------------------------------
// modular_inverse_euclid_unit_assert.svh
// assertion macros for the modular inverse unit
// ----------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_EUCLID_UNIT_ASSERT_SVH
`define MODULAR_INVERSE_EUCLID_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define MIE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define MIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mie_pkg.sv */
// ----------------------------------------------------------------------------
// mie_pkg
// widths, limits and sequencer states of the modular inverse unit
// ----------------------------------------------------------------------------
package mie_pkg;

  // datapath width; the round limit follows from it
  localparam int WIDTH     = 32;
  // width of value, modulus and inverse words
  localparam int VAL_W     = 31;
  // signed coefficient width, holds magnitudes up to the modulus with margin
  localparam int CW        = VAL_W + 2;
  // most rounds allowed per word
  localparam int ROUND_MAX = 2 * WIDTH;
  localparam int RND_W     = $clog2(ROUND_MAX + 1);
  // divisor shift count, below the word width
  localparam int SH_W      = $clog2(VAL_W);

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ALIGN  = 4'b0010,
    ST_REDUCE = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

endpackage

/* hdl/modular_inverse_euclid_unit.sv */
// ----------------------------------------------------------------------------
// modular_inverse_euclid_unit
// multiplicative inverse modulo a configured modulus by extended euclid
// ----------------------------------------------------------------------------
// channel  direction  handshake                  payload
// in       input      in_valid_i / in_stall_o    in_value_i
// out      output     out_valid_o / out_stall_i  out_inverse_o, out_ok_o
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_modulus_i
//
// one word at a time: a new word is taken only once the current one has
//   left the finish state, and each quotient is formed by a shift-subtract
//   loop, one bit per cycle
// reset sets the modulus to 2^31-1 and empties the output register
// the next word is taken while a result still waits on a stalled output
// a finished word waits in the finish state only while the output is full
// ----------------------------------------------------------------------------
module modular_inverse_euclid_unit
  import mie_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration write
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [VAL_W-1:0] cfg_modulus_i,
  // input words
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [VAL_W-1:0] in_value_i,
  // result words
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [VAL_W-1:0] out_inverse_o,
  output logic             out_ok_o
);

  `include "modular_inverse_euclid_unit_assert.svh"

  state_e                  state_q, state_d;
  logic [VAL_W-1:0]        modulus_q;
  // remainder pair: ra is reduced by rb each round
  logic [VAL_W-1:0]        ra_q, ra_d, rb_q, rb_d;
  // coefficient pair
  logic signed [CW-1:0]    ta_q, ta_d, tb_q, tb_d;
  // shifted divisor and shifted coefficient
  logic [VAL_W-1:0]        d_q, d_d;
  logic signed [CW-1:0]    dt_q, dt_d;
  logic [SH_W-1:0]         k_q, k_d;
  logic [RND_W-1:0]        rounds_q, rounds_d;
  logic                    fail_q, fail_d;
  logic                    out_valid_q, out_valid_d;
  logic [VAL_W-1:0]        out_inverse_q, out_inverse_d;
  logic                    out_ok_q, out_ok_d;

  // shared shift-subtract unit
  logic                    can_shift;
  logic                    ge;
  logic [VAL_W-1:0]        r_sub;
  logic signed [CW-1:0]    t_sub;
  // final lift and range check
  logic signed [CW-1:0]    q_ext;
  logic signed [CW-1:0]    t_lift;
  logic                    ok_c;
  logic                    out_free;

  assign can_shift = ({d_q, 1'b0} <= {1'b0, ra_q}) && (k_q != SH_W'(VAL_W - 1));
  assign ge        = (d_q <= ra_q);
  assign r_sub     = ge ? (ra_q - d_q) : ra_q;
  assign t_sub     = ge ? (ta_q - dt_q) : ta_q;

  assign q_ext  = $signed({{(CW - VAL_W){1'b0}}, modulus_q});
  assign t_lift = ta_q[CW-1] ? (ta_q + q_ext) : ta_q;
  assign ok_c   = !fail_q && (ra_q == VAL_W'(1)) && !t_lift[CW-1]
                  && (t_lift != '0) && (t_lift < q_ext);

  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d       = state_q;
    ra_d          = ra_q;
    rb_d          = rb_q;
    ta_d          = ta_q;
    tb_d          = tb_q;
    d_d           = d_q;
    dt_d          = dt_q;
    k_d           = k_q;
    rounds_d      = rounds_q;
    fail_d        = fail_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_inverse_d = out_inverse_q;
    out_ok_d      = out_ok_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ra_d     = modulus_q;
          rb_d     = in_value_i;
          ta_d     = '0;
          tb_d     = CW'(1);
          d_d      = in_value_i;
          dt_d     = CW'(1);
          k_d      = '0;
          rounds_d = '0;
          fail_d   = (in_value_i == '0) || (modulus_q < VAL_W'(2));
          state_d  = fail_d ? ST_FINISH : ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        // shift the divisor up while it still fits under the remainder
        if (can_shift) begin
          d_d  = {d_q[VAL_W-2:0], 1'b0};
          dt_d = dt_q <<< 1;
          k_d  = k_q + SH_W'(1);
        end else begin
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        // one quotient bit per cycle
        if (k_q == '0) begin
          ra_d     = rb_q;
          rb_d     = r_sub;
          ta_d     = tb_q;
          tb_d     = t_sub;
          d_d      = r_sub;
          dt_d     = t_sub;
          rounds_d = rounds_q + RND_W'(1);
          if (r_sub == '0) begin
            state_d = ST_FINISH;
          end else if (rounds_d == RND_W'(ROUND_MAX)) begin
            fail_d  = 1'b1;
            state_d = ST_FINISH;
          end else begin
            state_d = ST_ALIGN;
          end
        end else begin
          ra_d = r_sub;
          ta_d = t_sub;
          d_d  = d_q >> 1;
          dt_d = dt_q >>> 1;
          k_d  = k_q - SH_W'(1);
        end
      end
      ST_FINISH: begin
        // hand the word over once the output register is free
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_ok_d      = ok_c;
          out_inverse_d = ok_c ? t_lift[VAL_W-1:0] : '0;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      modulus_q   <= {VAL_W{1'b1}};
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        modulus_q <= cfg_modulus_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    ra_q          <= ra_d;
    rb_q          <= rb_d;
    ta_q          <= ta_d;
    tb_q          <= tb_d;
    d_q           <= d_d;
    dt_q          <= dt_d;
    k_q           <= k_d;
    rounds_q      <= rounds_d;
    fail_q        <= fail_d;
    out_inverse_q <= out_inverse_d;
    out_ok_q      <= out_ok_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign out_inverse_o = out_inverse_q;
  assign out_ok_o      = out_ok_q;

  // checks
  `MIE_ASSERT_NOW(a_ok_in_range, out_valid_o && out_ok_o,
                  (out_inverse_o != '0) && (out_inverse_o < modulus_q),
                  "inverse out of range")
  `MIE_ASSERT_NOW(a_fail_zero, out_valid_o && !out_ok_o, out_inverse_o == '0,
                  "failed word with nonzero inverse")
  `MIE_ASSERT_NOW(a_divisor_nonzero, (state_q == ST_ALIGN) || (state_q == ST_REDUCE),
                  rb_q != '0, "zero divisor in a round")
  `MIE_ASSERT_NEXT(a_start, in_valid_i && !in_stall_o,
                   (state_q == ST_ALIGN) || (state_q == ST_FINISH),
                   "accepted word did not start")

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for modular_inverse_euclid_unit: a directed table of
// edge cases, then random words over several modulus settings, each result
// word checked against its typed answer or an extended euclid predictor
// ----------------------------------------------------------------------------
module tb
  import mie_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [VAL_W-1:0] PRIME_M     = 31'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] EVEN_TOP_M  = 31'h7FFF_FFFE;
  localparam logic [VAL_W-1:0] FIB46_M     = 31'd1836311903;
  localparam int               PHASES      = 11;
  localparam int               PHASE_WORDS = 78;
  localparam int               HOLD_CYCLES = 600;
  localparam int               DRAIN_TAIL  = 200;
  localparam int               CYCLE_LIMIT = 1_000_000;

  // one result word
  typedef struct packed {
    logic [VAL_W-1:0] inverse;
    logic             ok;
  } inv_result_t;

  // one row of directed stimulus; typed rows carry their own answer
  typedef struct packed {
    logic [VAL_W-1:0] modulus;
    logic [VAL_W-1:0] value;
    logic             typed;
    logic [VAL_W-1:0] inverse;
    logic             ok;
  } vector_t;

  localparam int N_DIRECTED = 24;
  localparam vector_t DIRECTED [N_DIRECTED] = '{
    // reset modulus, prime 2^31-1
    '{PRIME_M,     31'd0,          1'b1, 31'd0,          1'b0},
    '{PRIME_M,     31'd1,          1'b1, 31'd1,          1'b1},
    '{PRIME_M,     PRIME_M - 1,    1'b1, PRIME_M - 1,    1'b1},
    '{PRIME_M,     PRIME_M,        1'b1, 31'd0,          1'b0},
    '{PRIME_M,     31'd2,          1'b1, 31'd1073741824, 1'b1},
    '{PRIME_M,     31'd3,          1'b0, 31'd0,          1'b0},
    '{PRIME_M,     31'h5555_5555,  1'b0, 31'd0,          1'b0},
    '{PRIME_M,     31'h2AAA_AAAA,  1'b0, 31'd0,          1'b0},
    '{PRIME_M,     31'h4000_0000,  1'b1, 31'd2,          1'b1},
    // smallest legal modulus, values below, at and above it
    '{31'd2,       31'd1,          1'b1, 31'd1,          1'b1},
    '{31'd2,       31'd0,          1'b1, 31'd0,          1'b0},
    '{31'd2,       PRIME_M,        1'b0, 31'd0,          1'b0},
    '{31'd2,       31'd2,          1'b0, 31'd0,          1'b0},
    // modulus below two never inverts
    '{31'd1,       31'd1,          1'b1, 31'd0,          1'b0},
    '{31'd0,       31'd5,          1'b1, 31'd0,          1'b0},
    '{31'd0,       31'd0,          1'b1, 31'd0,          1'b0},
    // composite modulus: gcd not one, a coprime value, a value above modulus
    '{31'd1000000, 31'd500000,     1'b1, 31'd0,          1'b0},
    '{31'd1000000, 31'd7,          1'b0, 31'd0,          1'b0},
    '{31'd1000000, 31'd1000001,    1'b0, 31'd0,          1'b0},
    // consecutive fibonacci numbers for the longest run of rounds, then modulus less one
    '{FIB46_M,     31'd1134903170, 1'b0, 31'd0,          1'b0},
    '{FIB46_M,     FIB46_M - 1,    1'b0, 31'd0,          1'b0},
    // largest even modulus
    '{EVEN_TOP_M,  EVEN_TOP_M - 1, 1'b0, 31'd0,          1'b0},
    '{EVEN_TOP_M,  31'd1073741823, 1'b0, 31'd0,          1'b0},
    '{EVEN_TOP_M,  PRIME_M,        1'b0, 31'd0,          1'b0}
  };

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [VAL_W-1:0] cfg_modulus_i = '0;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic [VAL_W-1:0] in_value_i    = '0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  logic [VAL_W-1:0] out_inverse_o;
  logic             out_ok_o;

  inv_result_t      pending_q [$];
  inv_result_t      oldest;
  logic [VAL_W-1:0] modulus_cfg   = PRIME_M;
  int               in_gap_pct    = 0;
  int               out_stall_pct = 0;
  bit               hold_out      = 1'b0;
  int               mismatch_count = 0;
  int               cycle_count   = 0;

  modular_inverse_euclid_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_modulus_i (cfg_modulus_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_value_i    (in_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_inverse_o (out_inverse_o),
    .out_ok_o      (out_ok_o)
  );

  // clock, 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // extended euclid on signed 64-bit coefficients
  function automatic inv_result_t predict_inverse(logic [VAL_W-1:0] value,
                                                  logic [VAL_W-1:0] modulus);
    longint      coef, next_coef, rem, next_rem, quot, tmp, mod_l;
    int          rounds;
    inv_result_t res;
    res = '0;
    if (value == '0 || modulus < 2) return res;
    mod_l     = longint'(modulus);
    coef      = 0;
    next_coef = 1;
    rem       = mod_l;
    next_rem  = longint'(value);
    rounds    = 0;
    while (next_rem != 0) begin
      if (rounds >= ROUND_MAX) return res;
      rounds++;
      quot      = rem / next_rem;
      tmp       = coef - quot * next_coef;
      coef      = next_coef;
      next_coef = tmp;
      tmp       = rem - quot * next_rem;
      rem       = next_rem;
      next_rem  = tmp;
    end
    if (rem != 1) return res;
    if (coef < 0) coef = coef + mod_l;
    if (coef <= 0 || coef >= mod_l) return res;
    res.inverse = coef[VAL_W-1:0];
    res.ok      = 1'b1;
    return res;
  endfunction

  // mostly in-range operands, some zero, small or raw 31-bit words
  function automatic logic [VAL_W-1:0] pick_value(logic [VAL_W-1:0] modulus);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 4) return '0;
    if (sel < 10) return VAL_W'($urandom_range(1, 16));
    if (sel < 20 || modulus < 2) return VAL_W'($urandom);
    return VAL_W'($urandom_range(1, int'(modulus) - 1));
  endfunction

  function automatic logic [VAL_W-1:0] phase_modulus(int ph);
    case (ph)
      0:       return PRIME_M;
      1:       return 31'd2;
      2:       return VAL_W'($urandom) | 31'h4000_0001;
      3:       return 31'd65521;
      5:       return 31'd3;
      6:       return VAL_W'($urandom_range(2, 255));
      7:       return EVEN_TOP_M;
      8:       return FIB46_M;
      10:      return PRIME_M;
      default: return VAL_W'($urandom_range(2, int'(PRIME_M)));
    endcase
  endfunction

  // offer one word, record its answer once taken, maybe idle after
  task automatic offer_value(input logic [VAL_W-1:0] value, input inv_result_t want);
    in_valid_i <= 1'b1;
    in_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    pending_q.push_back(want);
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // drain the unit, then write the modulus
  task automatic set_modulus(input logic [VAL_W-1:0] modulus);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i   <= 1'b1;
    cfg_modulus_i <= modulus;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    modulus_cfg = modulus;
  endtask

  // main sequence
  initial begin
    inv_result_t      want;
    logic [VAL_W-1:0] value;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    in_gap_pct    = 20;
    out_stall_pct = 20;
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].modulus != modulus_cfg) set_modulus(DIRECTED[i].modulus);
      if (DIRECTED[i].typed) begin
        want.inverse = DIRECTED[i].inverse;
        want.ok      = DIRECTED[i].ok;
      end else begin
        want = predict_inverse(DIRECTED[i].value, modulus_cfg);
      end
      offer_value(DIRECTED[i].value, want);
    end

    // random phases, one modulus each
    for (int ph = 0; ph < PHASES; ph++) begin
      set_modulus(phase_modulus(ph));
      case (ph % 3)
        0: begin
          in_gap_pct    = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_gap_pct    = 15;
          out_stall_pct = 15;
        end
        default: begin
          in_gap_pct    = 40;
          out_stall_pct = 40;
        end
      endcase
      // long output hold while words keep coming
      if (ph == 4) begin
        in_gap_pct = 0;
        hold_out   = 1'b1;
      end
      if (ph == PHASES - 1) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        value = pick_value(modulus_cfg);
        offer_value(value, predict_inverse(value, modulus_cfg));
      end
    end

    // wait out the last results
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // output side stalls: random bursts and one long hold
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_out = 1'b0;
      end else if (rst_ni && $urandom_range(0, 99) < out_stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // compare each taken result word with the oldest answer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $error("result word with none expected: inverse %0d ok %0d",
               out_inverse_o, out_ok_o);
        mismatch_count++;
      end else begin
        oldest = pending_q.pop_front();
        if (out_inverse_o !== oldest.inverse) begin
          $error("inverse: expected %0d, got %0d", oldest.inverse, out_inverse_o);
          mismatch_count++;
        end
        if (out_ok_o !== oldest.ok) begin
          $error("ok: expected %0d, got %0d", oldest.ok, out_ok_o);
          mismatch_count++;
        end
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
